>>> design/tomc_pkg.sv
// ----------------------------------------------------------------------------
// tomc_pkg
// Shared types and constants for the multipath-capable reply classifier.
// ----------------------------------------------------------------------------
package tomc_pkg;

  // Item kind carried on the slave-side tuser.
  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_OPTION = 1'b1
  } opcode_e;

  // Verdict codes as they leave the block.
  typedef enum logic [1:0] {
    VERD_RESET     = 2'd0,
    VERD_MIRROR    = 2'd1,
    VERD_ABSENT    = 2'd2,
    VERD_SUPPORTED = 2'd3
  } verdict_e;

  // Option walk phases.
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_KIND = 3'd1,
    PH_LEN  = 3'd2,
    PH_SKIP = 3'd3,
    PH_KEY  = 3'd4,
    PH_DONE = 3'd5
  } phase_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_EXPECTED_KEY = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_CAPABLE_KIND = 1'b1;

  localparam logic [63:0] EXPECTED_KEY_RST = 64'd4242424242;
  localparam logic [7:0]  CAPABLE_KIND_RST = 8'd30;

  // Option kinds with fixed meaning.
  localparam logic [7:0] KIND_EOL = 8'd0;
  localparam logic [7:0] KIND_NOP = 8'd1;

  // Key bytes sit at option offsets KeyFirst..KeyLast.
  localparam logic [3:0] KEY_FIRST = 4'd4;
  localparam logic [3:0] KEY_LAST  = 4'd11;
  localparam logic [3:0] KEY_END   = 4'd12;

  // Result of one step of the parser.
  typedef struct packed {
    logic     valid;
    verdict_e verdict;
    logic     success;
  } result_t;

  // Status of the parser state, used for checking.
  typedef struct packed {
    logic idle;
    logic empty;
  } status_t;

endpackage

>>> design/tomc_parser.sv
// ----------------------------------------------------------------------------
// tomc_parser
// Option walk state and the per-item update; emits at most one result per item.
// ----------------------------------------------------------------------------
module tomc_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  tomc_pkg::opcode_e  opcode_i,
  input  logic               rst_flag_i,
  input  logic [3:0]         data_offset_i,
  input  logic [7:0]         option_byte_i,
  input  logic [63:0]        expected_key_i,
  input  logic [7:0]         capable_kind_i,
  output tomc_pkg::result_t  res_o,
  output tomc_pkg::status_t  stat_o
);

  logic                 rst_seen_q, rst_seen_d;
  logic [5:0]           bytes_left_q, bytes_left_d;
  tomc_pkg::phase_e     phase_q, phase_d;
  logic [5:0]           skip_q, skip_d;
  logic [3:0]           key_pos_q, key_pos_d;
  logic                 key_eq_q, key_eq_d;
  tomc_pkg::verdict_e   verdict_q, verdict_d;

  logic [2:0]           key_sel;
  logic [7:0]           key_byte;
  logic                 emit;

  // Key offset 4 meets the most significant byte of the key.
  assign key_sel  = 3'(tomc_pkg::KEY_LAST - key_pos_q);
  assign key_byte = expected_key_i[{key_sel, 3'b000} +: 8];

  always_comb begin
    rst_seen_d   = rst_seen_q;
    bytes_left_d = bytes_left_q;
    phase_d      = phase_q;
    skip_d       = skip_q;
    key_pos_d    = key_pos_q;
    key_eq_d     = key_eq_q;
    verdict_d    = verdict_q;
    emit         = 1'b0;

    if (step_i) begin
      if (opcode_i == tomc_pkg::OP_HEADER) begin
        rst_seen_d   = rst_flag_i;
        bytes_left_d = (data_offset_i >= 4'd5) ? ({data_offset_i, 2'b00} - 6'd20) : 6'd0;
        skip_d       = 6'd0;
        key_pos_d    = 4'd0;
        key_eq_d     = 1'b1;
        verdict_d    = rst_flag_i ? tomc_pkg::VERD_RESET : tomc_pkg::VERD_ABSENT;
        phase_d      = rst_flag_i ? tomc_pkg::PH_DONE : tomc_pkg::PH_KIND;
        emit         = (bytes_left_d == 6'd0);
      end else if (phase_q != tomc_pkg::PH_IDLE && bytes_left_q != 6'd0) begin
        bytes_left_d = bytes_left_q - 6'd1;
        case (phase_q)
          tomc_pkg::PH_KIND: begin
            if (option_byte_i == tomc_pkg::KIND_EOL) begin
              phase_d = tomc_pkg::PH_DONE;
            end else if (option_byte_i == tomc_pkg::KIND_NOP) begin
              phase_d = tomc_pkg::PH_KIND;
            end else if (option_byte_i == capable_kind_i) begin
              phase_d   = tomc_pkg::PH_KEY;
              key_pos_d = 4'd1;
              key_eq_d  = 1'b1;
            end else if (bytes_left_d < 6'd2) begin
              phase_d = tomc_pkg::PH_DONE;
            end else begin
              phase_d = tomc_pkg::PH_LEN;
            end
          end
          tomc_pkg::PH_LEN: begin
            // The length counts the kind and length bytes themselves.
            if (option_byte_i < 8'd2 ||
                option_byte_i > ({2'b00, bytes_left_d} + 8'd1)) begin
              phase_d = tomc_pkg::PH_DONE;
            end else begin
              skip_d  = 6'(option_byte_i - 8'd2);
              phase_d = (skip_d == 6'd0) ? tomc_pkg::PH_KIND : tomc_pkg::PH_SKIP;
            end
          end
          tomc_pkg::PH_SKIP: begin
            skip_d = skip_q - 6'd1;
            if (skip_d == 6'd0) begin
              phase_d = tomc_pkg::PH_KIND;
            end
          end
          tomc_pkg::PH_KEY: begin
            if (key_pos_q >= tomc_pkg::KEY_FIRST && key_pos_q <= tomc_pkg::KEY_LAST &&
                key_byte != option_byte_i) begin
              key_eq_d = 1'b0;
            end
            key_pos_d = key_pos_q + 4'd1;
            if (key_pos_d >= tomc_pkg::KEY_END) begin
              verdict_d = key_eq_d ? tomc_pkg::VERD_MIRROR : tomc_pkg::VERD_SUPPORTED;
              phase_d   = tomc_pkg::PH_DONE;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
        if (bytes_left_d == 6'd0) begin
          // An option area that ends inside the key is a mismatch.
          if (phase_d == tomc_pkg::PH_KEY) begin
            verdict_d = tomc_pkg::VERD_SUPPORTED;
          end
          emit = 1'b1;
        end
      end
    end

    if (emit) begin
      phase_d = tomc_pkg::PH_IDLE;
    end
  end

  always_comb begin
    res_o.valid   = emit;
    res_o.verdict = rst_seen_d ? tomc_pkg::VERD_RESET : verdict_d;
    res_o.success = ~rst_seen_d;
    stat_o.idle   = (phase_q == tomc_pkg::PH_IDLE);
    stat_o.empty  = (bytes_left_q == 6'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_seen_q   <= 1'b0;
      bytes_left_q <= 6'd0;
      phase_q      <= tomc_pkg::PH_IDLE;
      skip_q       <= 6'd0;
      key_pos_q    <= 4'd0;
      key_eq_q     <= 1'b1;
      verdict_q    <= tomc_pkg::VERD_ABSENT;
    end else begin
      rst_seen_q   <= rst_seen_d;
      bytes_left_q <= bytes_left_d;
      phase_q      <= phase_d;
      skip_q       <= skip_d;
      key_pos_q    <= key_pos_d;
      key_eq_q     <= key_eq_d;
      verdict_q    <= verdict_d;
    end
  end

endmodule

>>> design/tcp_option_mptcp_classifier.sv
// ----------------------------------------------------------------------------
// tcp_option_mptcp_classifier
// Classifies a TCP reply to a multipath-capable SYN probe from its options.
// ----------------------------------------------------------------------------
// The block takes one word per cycle on its slave side: a header word (RST
// flag and data offset) followed by the option bytes of that segment, one
// byte per word. Each word is absorbed by the option walk state when accepted; the
// only pipeline stage is the result register on the master side, so the
// sustained rate is one word per clock unless that register stalls the slave
// side, and a verdict appears in the cycle after the last option byte (or a
// header with an empty option area) is accepted. The slave side accepts
// while the result register is empty or is drained in the same cycle. The
// walk stops at end-of-list, steps over no-operation bytes and skips other
// options by their length. A malformed length ends the walk with the verdict
// "absent". When the configured capable kind is found, option bytes 4 to 11
// are compared, most significant first, with the configured key: a full
// match gives "key mirrored", anything else (including a key cut short by
// the end of the option area) gives "supported". A reset reply always gives
// the verdict "reset" with success low. An option byte arriving outside a
// segment is dropped, and a new header abandons a segment in progress
// without a verdict. Configuration must only be written while the block is
// idle.
module tcp_option_mptcp_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [tomc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [63:0]                   cfg_wdata_i,
  // Slave side.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [15:0]                   s_axis_tdata_i,  // rst_flag, data_offset[3:0],
                                                         // option_byte[7:0], zero pad
  input  logic                          s_axis_tuser_i,  // opcode
  // Master side.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [7:0]                    m_axis_tdata_o   // verdict[1:0], success, zero pad
);

  logic [63:0]         expected_key_q;
  logic [7:0]          capable_kind_q;

  logic                out_valid_q, out_valid_d;
  tomc_pkg::verdict_e  out_verdict_q;
  logic                out_success_q;

  logic                in_accept;
  tomc_pkg::result_t   res;
  tomc_pkg::status_t   stat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_key_q <= tomc_pkg::EXPECTED_KEY_RST;
      capable_kind_q <= tomc_pkg::CAPABLE_KIND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tomc_pkg::REG_EXPECTED_KEY: expected_key_q <= cfg_wdata_i;
        tomc_pkg::REG_CAPABLE_KIND: capable_kind_q <= cfg_wdata_i[7:0];
        default: expected_key_q <= expected_key_q;
      endcase
    end
  end

  // A word can enter whenever the result register is free or being emptied,
  // so a new verdict never overwrites one still waiting.
  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;

  tomc_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (in_accept),
    .opcode_i       (tomc_pkg::opcode_e'(s_axis_tuser_i)),
    .rst_flag_i     (s_axis_tdata_i[0]),
    .data_offset_i  (s_axis_tdata_i[4:1]),
    .option_byte_i  (s_axis_tdata_i[12:5]),
    .expected_key_i (expected_key_q),
    .capable_kind_i (capable_kind_q),
    .res_o          (res),
    .stat_o         (stat)
  );

  // Result register.
  always_comb begin
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_verdict_q <= res.verdict;
      out_success_q <= res.success;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000, out_success_q, out_verdict_q};

  // Success is low exactly when the verdict is reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[2] == (m_axis_tdata_o[1:0] != tomc_pkg::VERD_RESET)))
    else $error("success flag disagrees with verdict");

  // Once the option area is used up the walk must have returned to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.empty |-> stat.idle)
    else $error("walk left active with no option bytes remaining");

  // A drained verdict with no new one behind it clears the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !res.valid) |=> !m_axis_tvalid_o)
    else $error("verdict repeated after it was taken");

  // A verdict is only produced for an accepted word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> in_accept)
    else $error("verdict produced without an accepted word");

endmodule

>>> test/tcp_option_mptcp_classifier_test.sv
// ----------------------------------------------------------------------------
// tcp_option_mptcp_classifier_test
// Self-checking testbench for the multipath-capable reply classifier.
// ----------------------------------------------------------------------------
// A short table of hand-picked words comes first: empty option areas, reset
// replies, a stray option byte, a header that abandons a segment, a broken
// length and a key that is echoed exactly. After that, random segments are
// sent under several register settings, the extremes included. Most segments
// are well-formed option lists with random content; the rest are noise,
// broken lengths and segments cut short by the next header. A behavioural
// model of the option walk predicts each verdict, and every word that leaves
// the master side is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tcp_option_mptcp_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any word taken on either side before the run is declared hung.
  localparam int StallLimit = 1000;
  // Random segment words (headers and option bytes) spread over the register settings.
  localparam int RandomWords = 1450;
  localparam int NumSettings = 6;

  // One verdict as it leaves the block.
  typedef struct packed {
    tomc_pkg::verdict_e verdict;
    logic               success;
  } verdict_word_t;

  // One row of the directed table. Where typed is set, the verdict that
  // the row must produce is written out; elsewhere the model decides.
  typedef struct packed {
    tomc_pkg::opcode_e  op;
    logic               rst;
    logic [3:0]         doff;
    logic [7:0]         optb;
    logic               typed;
    tomc_pkg::verdict_e verd;
    logic               succ;
  } stim_row_t;

  localparam stim_row_t DirectedRows [28] = '{
    // Short data offset: empty option area, verdict at the header.
    '{tomc_pkg::OP_HEADER, 1'b0, 4'd0,  8'h00, 1'b1, tomc_pkg::VERD_ABSENT, 1'b1},
    // Reset reply with no options.
    '{tomc_pkg::OP_HEADER, 1'b1, 4'd5,  8'h00, 1'b1, tomc_pkg::VERD_RESET,  1'b0},
    // Option byte while no segment is open: dropped silently.
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'hff, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    // A segment abandoned after one NOP by a fresh header.
    '{tomc_pkg::OP_HEADER, 1'b0, 4'd6,  8'h00, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'h01, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_HEADER, 1'b0, 4'd6,  8'h00, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    // Plain kind followed by a length below two: walk stops, absent.
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'h05, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'h01, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'h00, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'hff, 1'b1, tomc_pkg::VERD_ABSENT, 1'b1},
    // Reset reply carrying options: they are swallowed unparsed.
    '{tomc_pkg::OP_HEADER, 1'b1, 4'd6,  8'h00, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'h1e, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'h00, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'hff, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'h80, 1'b1, tomc_pkg::VERD_RESET,  1'b0},
    // Capable option with a zero length byte (never checked) and the
    // reset key 00000000_fcde41b2 echoed back: key mirrored.
    '{tomc_pkg::OP_HEADER, 1'b0, 4'd8,  8'h00, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'h1e, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'h00, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'hff, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'hff, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'h00, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'h00, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'h00, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'h00, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'hfc, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'hde, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'h41, 1'b0, tomc_pkg::VERD_RESET,  1'b0},
    '{tomc_pkg::OP_OPTION, 1'b0, 4'd0,  8'hb2, 1'b1, tomc_pkg::VERD_MIRROR, 1'b1}
  };

  // Clock, reset and the ports of the block. Everything starts at a known
  // value so that nothing undefined reaches the block.
  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [tomc_pkg::CfgIdxW-1:0]  cfg_idx = tomc_pkg::REG_EXPECTED_KEY;
  logic [63:0]                   cfg_wdata = '0;
  logic                          s_valid = 1'b0;
  logic                          s_ready;
  logic [15:0]                   s_data = '0;
  tomc_pkg::opcode_e             s_user = tomc_pkg::OP_HEADER;
  logic                          m_valid;
  logic                          m_ready = 1'b0;
  logic [7:0]                    m_data;

  // Typed expectation travelling alongside the word on the slave side.
  logic                          s_typed = 1'b0;
  tomc_pkg::verdict_e            s_tverd = tomc_pkg::VERD_RESET;
  logic                          s_tsucc = 1'b0;

  // While calm is set neither side inserts idle cycles.
  bit                            calm = 1'b0;

  logic                          in_taken;
  logic                          out_taken;
  int                            stall_cycles = 0;
  int                            errors = 0;
  int                            random_words = 0;

  // Verdicts still to come out of the block, oldest first.
  verdict_word_t                 verdict_fifo [$];

  // Model copy of the registers and of the option walk state.
  logic [63:0]                   key_cfg = tomc_pkg::EXPECTED_KEY_RST;
  logic [7:0]                    kind_cfg = tomc_pkg::CAPABLE_KIND_RST;
  logic                          rst_m = 1'b0;
  logic [5:0]                    left_m = '0;
  tomc_pkg::phase_e              phase_m = tomc_pkg::PH_IDLE;
  logic [5:0]                    skip_m = '0;
  logic [3:0]                    keypos_m = '0;
  logic                          keyeq_m = 1'b1;
  tomc_pkg::verdict_e            verd_m = tomc_pkg::VERD_ABSENT;

  tcp_option_mptcp_classifier dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // rst_flag, data_offset[3:0], option_byte[7:0], zero pad
    .s_axis_tuser_i  (s_user),   // opcode
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)    // verdict[1:0], success, zero pad
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  assign in_taken  = s_valid && s_ready;
  assign out_taken = m_valid && m_ready;

  // Word builders for the slave-side tdata layout.
  function automatic logic [15:0] header_word(logic rst, logic [3:0] doff, logic [7:0] junk);
    return {3'b000, junk, doff, rst};
  endfunction

  function automatic logic [15:0] option_word(logic [7:0] b, logic [4:0] junk);
    return {3'b000, b, junk};
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    errors++;
  endtask

  // Advances the model by one accepted word. A header opens a segment; each
  // option byte is walked until the option area is used up, at which point
  // the verdict is produced. A header with an empty area gives it at once.
  task automatic classify_word(input tomc_pkg::opcode_e op, input logic rst,
                               input logic [3:0] doff, input logic [7:0] b,
                               output bit has, output verdict_word_t res);
    int sh;
    has = 1'b0;
    res = '{tomc_pkg::VERD_ABSENT, 1'b1};
    if (op == tomc_pkg::OP_HEADER) begin
      rst_m    = rst;
      left_m   = (doff >= 4'd5) ? 6'(doff * 4 - 20) : 6'd0;
      skip_m   = '0;
      keypos_m = '0;
      keyeq_m  = 1'b1;
      verd_m   = rst ? tomc_pkg::VERD_RESET : tomc_pkg::VERD_ABSENT;
      phase_m  = rst ? tomc_pkg::PH_DONE : tomc_pkg::PH_KIND;
      has      = (left_m == 6'd0);
    end else if (phase_m != tomc_pkg::PH_IDLE && left_m != 6'd0) begin
      left_m = left_m - 6'd1;
      case (phase_m)
        tomc_pkg::PH_KIND: begin
          // End-of-list is tested first, then no-op, then the capable kind.
          if (b == tomc_pkg::KIND_EOL) begin
            phase_m = tomc_pkg::PH_DONE;
          end else if (b == tomc_pkg::KIND_NOP) begin
            phase_m = tomc_pkg::PH_KIND;
          end else if (b == kind_cfg) begin
            phase_m  = tomc_pkg::PH_KEY;
            keypos_m = 4'd1;
            keyeq_m  = 1'b1;
          end else if (left_m < 6'd2) begin
            phase_m = tomc_pkg::PH_DONE;
          end else begin
            phase_m = tomc_pkg::PH_LEN;
          end
        end
        tomc_pkg::PH_LEN: begin
          // The kind byte stood with one more byte left than now.
          if (b < 8'd2 || int'(b) > int'(left_m) + 1) begin
            phase_m = tomc_pkg::PH_DONE;
          end else begin
            skip_m  = 6'(b - 8'd2);
            phase_m = (skip_m == 6'd0) ? tomc_pkg::PH_KIND : tomc_pkg::PH_SKIP;
          end
        end
        tomc_pkg::PH_SKIP: begin
          skip_m = skip_m - 6'd1;
          if (skip_m == 6'd0)
            phase_m = tomc_pkg::PH_KIND;
        end
        tomc_pkg::PH_KEY: begin
          if (keypos_m >= tomc_pkg::KEY_FIRST && keypos_m <= tomc_pkg::KEY_LAST) begin
            sh = int'(tomc_pkg::KEY_LAST - keypos_m) * 8;
            if (key_cfg[sh +: 8] != b)
              keyeq_m = 1'b0;
          end
          keypos_m = keypos_m + 4'd1;
          if (keypos_m >= tomc_pkg::KEY_END) begin
            verd_m  = keyeq_m ? tomc_pkg::VERD_MIRROR : tomc_pkg::VERD_SUPPORTED;
            phase_m = tomc_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
      if (left_m == 6'd0) begin
        // A key cut short by the end of the area counts as a mismatch.
        if (phase_m == tomc_pkg::PH_KEY)
          verd_m = tomc_pkg::VERD_SUPPORTED;
        has = 1'b1;
      end
    end
    if (has) begin
      res.verdict = rst_m ? tomc_pkg::VERD_RESET : verd_m;
      res.success = !rst_m;
      phase_m     = tomc_pkg::PH_IDLE;
    end
  endtask

  // Both handshakes are evaluated on the values that stood before the edge.
  // The slave side is handled first so that a verdict could never overtake
  // its own prediction.
  always @(posedge clk) begin : scoreboard
    bit            has;
    verdict_word_t want;
    verdict_word_t got;
    if (rst_n) begin
      if (in_taken) begin
        classify_word(s_user, s_data[0], s_data[4:1], s_data[12:5], has, want);
        if (s_typed) begin
          has  = 1'b1;
          want = '{s_tverd, s_tsucc};
        end
        if (has)
          verdict_fifo.push_back(want);
      end
      if (out_taken) begin
        got.verdict = tomc_pkg::verdict_e'(m_data[1:0]);
        got.success = m_data[2];
        if (verdict_fifo.size() == 0) begin
          report_mismatch($sformatf("unexpected verdict word %0d/%0b",
                                    got.verdict, got.success));
        end else begin
          want = verdict_fifo.pop_front();
          if (got.verdict != want.verdict)
            report_mismatch($sformatf("verdict %0d, expected %0d",
                                      got.verdict, want.verdict));
          if (got.success != want.success)
            report_mismatch($sformatf("success %0b, expected %0b",
                                      got.success, want.success));
        end
      end
    end
  end

  // The receiver stalls on about a quarter of the cycles unless calm.
  always @(posedge clk) begin
    m_ready <= calm || ($urandom_range(99) >= 24);
  end

  // Watchdog: a run that stops moving words is a failure.
  always @(posedge clk) begin : watchdog
    if (!rst_n || in_taken || out_taken)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Presents one word and holds it until the block takes it. Idle gaps are
  // inserted at random before the word unless calm is set.
  task automatic send_word(input tomc_pkg::opcode_e op, input logic [15:0] data,
                           input logic typed, input tomc_pkg::verdict_e tverd,
                           input logic tsucc);
    if (!calm && $urandom_range(99) < 12) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= data;
    s_user  <= op;
    s_typed <= typed;
    s_tverd <= tverd;
    s_tsucc <= tsucc;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  // Holds the sender back until every predicted verdict has come out, then
  // idles on so that the result register is surely empty.
  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk); while (verdict_fifo.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Both registers are written back to back with the block idle.
  task automatic configure(input logic [63:0] key, input logic [7:0] kind);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= tomc_pkg::REG_EXPECTED_KEY;
    cfg_wdata <= key;
    @(posedge clk);
    key_cfg = key;
    cfg_idx   <= tomc_pkg::REG_CAPABLE_KIND;
    cfg_wdata <= {56'd0, kind};
    @(posedge clk);
    kind_cfg = kind;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one random segment: header plus option bytes. Most segments are
  // built as proper option lists (NOPs, plain options with sound lengths,
  // a capable option carrying the configured key with the odd flipped bit);
  // some are pure noise, some carry broken lengths, and a few are cut off.
  task automatic send_packet();
    logic [7:0] opts [$];
    logic [7:0] kind;
    logic [7:0] kb;
    logic       rst;
    int         doff;
    int         n;
    int         room;
    int         len;
    int         r;
    int         cut;
    bit         capable_done;
    capable_done = 1'b0;
    rst  = ($urandom_range(99) < 10);
    doff = ($urandom_range(99) < 6) ? $urandom_range(0, 4) : $urandom_range(5, 15);
    n    = (doff >= 5) ? doff * 4 - 20 : 0;
    if ($urandom_range(99) < 12) begin
      repeat (n) opts.push_back(8'($urandom));
    end else begin
      while (opts.size() < n) begin
        room = n - opts.size();
        r    = $urandom_range(99);
        if (r < 15) begin
          opts.push_back(tomc_pkg::KIND_NOP);
        end else if (r < 22) begin
          opts.push_back(tomc_pkg::KIND_EOL);
          while (opts.size() < n) opts.push_back(8'($urandom));
        end else if (r < 55 && !capable_done) begin
          capable_done = 1'b1;
          opts.push_back(kind_cfg);
          opts.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'd12);
          opts.push_back(8'($urandom));
          opts.push_back(8'($urandom));
          for (int j = 0; j < 8; j++) begin
            kb = key_cfg[63 - 8 * j -: 8];
            if ($urandom_range(99) < 4)
              kb = kb ^ 8'(1 << $urandom_range(7));
            opts.push_back(kb);
          end
        end else begin
          do kind = 8'($urandom_range(2, 255)); while (kind == kind_cfg);
          opts.push_back(kind);
          if (room >= 2) begin
            r = $urandom_range(99);
            if (r < 6) begin
              opts.push_back(8'($urandom_range(0, 1)));
            end else if (r < 12) begin
              opts.push_back(8'(room + 1 + $urandom_range(0, 8)));
            end else begin
              len = $urandom_range(2, (room < 12) ? room : 12);
              opts.push_back(8'(len));
              repeat (len - 2) opts.push_back(8'($urandom));
            end
          end
        end
      end
      while (opts.size() > n) void'(opts.pop_back());
    end
    // A segment occasionally ends early; the next header abandons it.
    if (n > 0 && $urandom_range(99) < 5) begin
      cut = $urandom_range(0, n - 1);
      while (opts.size() > cut) void'(opts.pop_back());
    end
    // Stray option bytes between segments are dropped by the block.
    if ($urandom_range(99) < 4)
      repeat ($urandom_range(1, 2))
        send_word(tomc_pkg::OP_OPTION, option_word(8'($urandom), 5'($urandom)), 1'b0,
                  tomc_pkg::VERD_RESET, 1'b0);
    send_word(tomc_pkg::OP_HEADER, header_word(rst, 4'(doff), 8'($urandom)), 1'b0,
              tomc_pkg::VERD_RESET, 1'b0);
    random_words++;
    foreach (opts[i]) begin
      send_word(tomc_pkg::OP_OPTION, option_word(opts[i], 5'($urandom)), 1'b0,
                tomc_pkg::VERD_RESET, 1'b0);
      random_words++;
    end
  endtask

  initial begin : stimulus
    logic [63:0] key;
    logic [7:0]  kind;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, with the registers still at their reset values.
    for (int i = 0; i < $size(DirectedRows); i++) begin
      if (DirectedRows[i].op == tomc_pkg::OP_HEADER)
        send_word(tomc_pkg::OP_HEADER, header_word(DirectedRows[i].rst, DirectedRows[i].doff,
                  DirectedRows[i].optb), DirectedRows[i].typed, DirectedRows[i].verd,
                  DirectedRows[i].succ);
      else
        send_word(tomc_pkg::OP_OPTION, option_word(DirectedRows[i].optb, 5'd0),
                  DirectedRows[i].typed, DirectedRows[i].verd, DirectedRows[i].succ);
    end

    // Random segments under a series of register settings. The second
    // setting runs with no idling on either side.
    for (int p = 0; p < NumSettings; p++) begin
      case (p)
        0: begin
          key  = {$urandom, $urandom};
          kind = tomc_pkg::CAPABLE_KIND_RST;
        end
        1: begin
          key  = '1;
          kind = 8'd255;
        end
        2: begin
          key  = '0;
          kind = tomc_pkg::KIND_EOL;
        end
        3: begin
          key  = {$urandom, $urandom};
          kind = tomc_pkg::KIND_NOP;
        end
        4: begin
          key  = {$urandom, $urandom};
          kind = 8'($urandom_range(2, 254));
        end
        default: begin
          key  = {$urandom, $urandom};
          kind = tomc_pkg::CAPABLE_KIND_RST;
        end
      endcase
      configure(key, kind);
      calm = (p == 1);
      while (random_words < (p + 1) * RandomWords / NumSettings)
        send_packet();
      // Close the setting with an empty segment so no walk is left open.
      send_word(tomc_pkg::OP_HEADER, header_word(1'b0, 4'd5, 8'd0), 1'b0,
                tomc_pkg::VERD_RESET, 1'b0);
    end
    calm = 1'b0;

    drain();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
design/tomc_pkg.sv
design/tomc_parser.sv
design/tcp_option_mptcp_classifier.sv
test/tcp_option_mptcp_classifier_test.sv
